[hdl/itl_pkg.sv]
// shared constants, codes and types for the interpolated table lookup
// no dependencies; every other file in hdl/ except itl_ram imports this package
package itl_pkg;

    // table and number formats
    localparam int TABLE_DEPTH     = 1024;
    localparam int SAMPLE_WIDTH    = 24;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int ADDR_W          = $clog2(TABLE_DEPTH);
    localparam int LEN_W           = ADDR_W + 1;
    localparam int PHASE_W         = 32;
    localparam int CFG_W           = 32;

    // normalisation datapath
    localparam int DIFF_W  = PHASE_W + 1;
    localparam int SPLIT_W = 16;
    localparam int PART_W  = CFG_W + DIFF_W - SPLIT_W;
    localparam int PROD_W  = CFG_W + DIFF_W;
    localparam int U_W     = PHASE_FRAC_BITS + 1;
    localparam int POS_W   = U_W + LEN_W;
    localparam int IDX_W   = POS_W - PHASE_FRAC_BITS;

    // interpolation datapath
    localparam int SLOPE_W = SAMPLE_WIDTH + 1;
    localparam int WPROD_W = SLOPE_W + PHASE_FRAC_BITS + 1;
    localparam int SUM_W   = WPROD_W - PHASE_FRAC_BITS + 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_BIAS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = 3'd3;

    localparam logic signed [CFG_W-1:0] SCALE_ONE  = CFG_W'(1) << PHASE_FRAC_BITS;
    localparam logic [LEN_W-1:0]        LEN_RESET  = LEN_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]        LEN_MIN    = LEN_W'(2);
    localparam logic [U_W-1:0]          U_ONE      = U_W'(1) << PHASE_FRAC_BITS;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_RAW    = 2'd2;

    typedef struct packed {
        logic [1:0]                     op;
        logic [ADDR_W-1:0]              index;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic signed [DIFF_W-1:0]       diff;
    } t_item;

    typedef struct packed {
        logic signed [CFG_W-1:0] scale;
        logic                    periodic;
        logic [LEN_W-1:0]        length;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hdl/interpolated_table_lookup.sv]
// top level of the interpolated table lookup: configuration registers and
// the front / queue / back split; depends on itl_pkg, itl_front, itl_queue,
// itl_back and itl_ram
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------------
//  in      | in        | i_in_valid / o_in_stall     | i_opcode i_entry_index
//          |           |                             | i_entry_value i_phase
//  out     | out       | o_out_valid / i_out_stall   | o_sample_out
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index i_cfg_data
//
// one item per cycle sustained while the output is not held; a result passes
// through the seven back stages (two-part multiply, normalise, position
// multiply, table addresses, ram read, slope, weight multiply) and then the output register
// writes reach the table in item order
// reset is synchronous, active low: config returns to its defaults, queue and
// stage valids clear; table contents are left as they are, no clearing pass
// a held output freezes the whole back pipeline; the four-item queue soaks
// up what the front has taken and o_in_stall rises when it is full
module interpolated_table_lookup import itl_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [ADDR_W-1:0]             i_entry_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_entry_value,
    input  logic signed [PHASE_W-1:0]     i_phase,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    logic signed [CFG_W-1:0] r_norm_bias;
    logic signed [CFG_W-1:0] r_norm_scale;
    logic                    r_periodic_mode;
    logic [LEN_W-1:0]        r_table_length;

    logic [LEN_W-1:0] n_len_eff;
    t_cfg             n_cfg;
    t_item            n_push_item;
    t_item            n_head;
    t_q_status        n_q_status;
    logic             n_push;
    logic             n_pop;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_bias     <= '0;
            r_norm_scale    <= SCALE_ONE;
            r_periodic_mode <= 1'b1;
            r_table_length  <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NORM_BIAS:     r_norm_bias     <= $signed(i_cfg_data);
                CFG_NORM_SCALE:    r_norm_scale    <= $signed(i_cfg_data);
                CFG_PERIODIC_MODE: r_periodic_mode <= i_cfg_data[0];
                CFG_TABLE_LENGTH:  r_table_length  <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // index beyond the register list: nothing to write
                end
            endcase
        end
    end

    // length outside [2, depth] acts as the nearest bound
    always_comb begin
        if (r_table_length < LEN_MIN) begin
            n_len_eff = LEN_MIN;
        end else if (r_table_length > LEN_RESET) begin
            n_len_eff = LEN_RESET;
        end else begin
            n_len_eff = r_table_length;
        end
    end

    assign n_cfg.scale    = r_norm_scale;
    assign n_cfg.periodic = r_periodic_mode;
    assign n_cfg.length   = n_len_eff;

    itl_front u_front (
        .i_valid       (i_in_valid),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_phase       (i_phase),
        .i_norm_bias   (r_norm_bias),
        .i_q_status    (n_q_status),
        .o_stall       (o_in_stall),
        .o_push        (n_push),
        .o_item        (n_push_item)
    );

    itl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (n_push),
        .i_item   (n_push_item),
        .i_pop    (n_pop),
        .o_head   (n_head),
        .o_status (n_q_status)
    );

    itl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (n_cfg),
        .i_head       (n_head),
        .i_q_status   (n_q_status),
        .o_pop        (n_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

[hdl/itl_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module itl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/itl_front.sv]
// front end: accepts items, drops unused opcodes, removes the phase bias
// depends on itl_pkg; feeds itl_queue
module itl_front import itl_pkg::*; (
    input  logic                     i_valid,
    input  logic [1:0]               i_opcode,
    input  logic [ADDR_W-1:0]        i_entry_index,
    input  logic signed [SAMPLE_WIDTH-1:0] i_entry_value,
    input  logic signed [PHASE_W-1:0] i_phase,
    input  logic signed [CFG_W-1:0]  i_norm_bias,
    input  t_q_status                i_q_status,
    output logic                     o_stall,
    output logic                     o_push,
    output t_item                    o_item
);

    logic n_accept;
    logic n_keep;

    assign o_stall  = i_q_status.full;
    assign n_accept = i_valid && !i_q_status.full;

    // unused opcode is taken and forgotten
    always_comb begin
        case (i_opcode)
            OP_WRITE, OP_LOOKUP, OP_RAW: n_keep = 1'b1;
            default:                     n_keep = 1'b0;
        endcase
    end

    assign o_push       = n_accept && n_keep;
    assign o_item.op    = i_opcode;
    assign o_item.index = i_entry_index;
    assign o_item.value = i_entry_value;
    assign o_item.diff  = DIFF_W'(i_phase) - DIFF_W'(i_norm_bias);

endmodule

[hdl/itl_queue.sv]
// short item queue between front and back
// depends on itl_pkg
module itl_queue import itl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("item pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("item popped from empty queue");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[QPTR_W-1:0] == QPTR_W'(r_wr_ptr - r_rd_ptr))
        && (r_count <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue count disagrees with pointers");

endmodule

[hdl/itl_back.sv]
// back end: normalisation, table access and interpolation pipeline
// depends on itl_pkg and itl_ram; takes items from itl_queue
module itl_back import itl_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_item                         i_head,
    input  t_q_status                     i_q_status,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic n_adv;

    // stage 1: partial products of diff * scale
    logic                          r_p1_valid;
    logic [1:0]                    r_p1_op;
    logic [ADDR_W-1:0]             r_p1_index;
    logic signed [SAMPLE_WIDTH-1:0] r_p1_value;
    logic signed [PART_W-1:0]      r_p1_lo;
    logic signed [PART_W-1:0]      r_p1_hi;
    logic signed [PART_W-1:0]      n_part_lo;
    logic signed [PART_W-1:0]      n_part_hi;

    // stage 2: normalised position u
    logic                          r_p2_valid;
    logic [1:0]                    r_p2_op;
    logic [ADDR_W-1:0]             r_p2_index;
    logic signed [SAMPLE_WIDTH-1:0] r_p2_value;
    logic [U_W-1:0]                r_p2_u;
    logic signed [PROD_W-1:0]      n_prod;
    logic [U_W-1:0]                n_u;

    // stage 3: table position and clamped raw index
    logic                          r_p3_valid;
    logic [1:0]                    r_p3_op;
    logic [ADDR_W-1:0]             r_p3_index;
    logic signed [SAMPLE_WIDTH-1:0] r_p3_value;
    logic [POS_W-1:0]              r_p3_pos;
    logic [ADDR_W-1:0]             r_p3_raw_ix;
    logic [LEN_W-1:0]              n_span;
    logic [LEN_W-1:0]              n_lm1;
    logic [POS_W-1:0]              n_pos;
    logic [ADDR_W-1:0]             n_raw_ix;

    // stage 4: table addresses, write port
    logic                          r_p4_valid;
    logic [1:0]                    r_p4_op;
    logic signed [SAMPLE_WIDTH-1:0] r_p4_value;
    logic [ADDR_W-1:0]             r_p4_addr_a;
    logic [ADDR_W-1:0]             r_p4_addr_b;
    logic [PHASE_FRAC_BITS-1:0]    r_p4_frac;
    logic [IDX_W-1:0]              n_idx;
    logic [IDX_W-1:0]              n_inc;
    logic [IDX_W-1:0]              n_len_x;
    logic [IDX_W-1:0]              n_lm1_x;
    logic [ADDR_W-1:0]             n_addr_a;
    logic [ADDR_W-1:0]             n_addr_b;
    logic [PHASE_FRAC_BITS-1:0]    n_frac;
    logic                          n_we;

    // stage 5: table data out of the rams
    logic                          r_p5_valid;
    logic [PHASE_FRAC_BITS-1:0]    r_p5_frac;
    logic [SAMPLE_WIDTH-1:0]       n_rd_a;
    logic [SAMPLE_WIDTH-1:0]       n_rd_b;

    // stage 6: slope
    logic                          r_p6_valid;
    logic [PHASE_FRAC_BITS-1:0]    r_p6_frac;
    logic signed [SAMPLE_WIDTH-1:0] r_p6_base;
    logic signed [SLOPE_W-1:0]     r_p6_slope;

    // stage 7: slope * fraction
    logic                          r_p7_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_p7_base;
    logic signed [WPROD_W-1:0]     r_p7_prod;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SAMPLE_WIDTH-1:0] n_sat;

    // whole pipeline moves together unless the result register is held
    assign n_adv = !r_out_valid || !i_out_stall;
    assign o_pop = n_adv && !i_q_status.empty;

    assign n_part_lo = $signed(i_cfg.scale) * $signed({1'b0, i_head.diff[SPLIT_W-1:0]});
    assign n_part_hi = $signed(i_cfg.scale) * $signed(i_head.diff[DIFF_W-1:SPLIT_W]);

    assign n_prod = $signed({r_p1_hi, {SPLIT_W{1'b0}}}) + PROD_W'(r_p1_lo);

    // wrap keeps the fraction, clamp pins to [0, 1.0]
    always_comb begin
        if (i_cfg.periodic) begin
            n_u = {1'b0, n_prod[2*PHASE_FRAC_BITS-1:PHASE_FRAC_BITS]};
        end else if (n_prod[PROD_W-1]) begin
            n_u = '0;
        end else if (|n_prod[PROD_W-2:2*PHASE_FRAC_BITS]) begin
            n_u = U_ONE;
        end else begin
            n_u = {1'b0, n_prod[2*PHASE_FRAC_BITS-1:PHASE_FRAC_BITS]};
        end
    end

    assign n_lm1    = i_cfg.length - LEN_W'(1);
    assign n_span   = i_cfg.periodic ? i_cfg.length : n_lm1;
    assign n_pos    = POS_W'(r_p2_u) * POS_W'(n_span);
    assign n_raw_ix = ({1'b0, r_p2_index} > n_lm1) ? n_lm1[ADDR_W-1:0] : r_p2_index;

    assign n_idx   = r_p3_pos[POS_W-1:PHASE_FRAC_BITS];
    assign n_inc   = n_idx + IDX_W'(1);
    assign n_len_x = IDX_W'(i_cfg.length);
    assign n_lm1_x = IDX_W'(n_lm1);

    always_comb begin
        n_addr_a = r_p3_index;
        n_addr_b = r_p3_index;
        n_frac   = '0;
        case (r_p3_op)
            OP_LOOKUP: begin
                if (i_cfg.periodic) begin
                    // last entry leans on entry zero
                    n_addr_a = n_idx[ADDR_W-1:0];
                    n_addr_b = (n_inc >= n_len_x) ? '0 : n_inc[ADDR_W-1:0];
                    n_frac   = r_p3_pos[PHASE_FRAC_BITS-1:0];
                end else if (n_idx >= n_lm1_x) begin
                    // last entry has no slope
                    n_addr_a = n_lm1[ADDR_W-1:0];
                    n_addr_b = n_lm1[ADDR_W-1:0];
                end else begin
                    n_addr_a = n_idx[ADDR_W-1:0];
                    n_addr_b = n_inc[ADDR_W-1:0];
                    n_frac   = r_p3_pos[PHASE_FRAC_BITS-1:0];
                end
            end
            OP_RAW: begin
                n_addr_a = r_p3_raw_ix;
                n_addr_b = r_p3_raw_ix;
            end
            default: begin
                n_addr_a = r_p3_index;
                n_addr_b = r_p3_index;
            end
        endcase
    end

    assign n_we = n_adv && r_p4_valid && (r_p4_op == OP_WRITE);

    // two copies of the table, one per read port
    itl_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_p4_addr_a),
        .i_wdata (r_p4_value),
        .i_re    (n_adv),
        .i_raddr (r_p4_addr_a),
        .o_rdata (n_rd_a)
    );

    itl_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_p4_addr_a),
        .i_wdata (r_p4_value),
        .i_re    (n_adv),
        .i_raddr (r_p4_addr_b),
        .o_rdata (n_rd_b)
    );

    assign n_sum = SUM_W'(r_p7_base)
                 + SUM_W'($signed(r_p7_prod[WPROD_W-1:PHASE_FRAC_BITS]));

    always_comb begin
        if (n_sum > SUM_W'(SAMPLE_MAX)) begin
            n_sat = SAMPLE_MAX;
        end else if (n_sum < SUM_W'(SAMPLE_MIN)) begin
            n_sat = SAMPLE_MIN;
        end else begin
            n_sat = n_sum[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_p5_valid  <= 1'b0;
            r_p6_valid  <= 1'b0;
            r_p7_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_p1_valid  <= !i_q_status.empty;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_p5_valid  <= r_p4_valid && (r_p4_op != OP_WRITE);
            r_p6_valid  <= r_p5_valid;
            r_p7_valid  <= r_p6_valid;
            r_out_valid <= r_p7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_p1_op      <= i_head.op;
            r_p1_index   <= i_head.index;
            r_p1_value   <= i_head.value;
            r_p1_lo      <= n_part_lo;
            r_p1_hi      <= n_part_hi;
            r_p2_op      <= r_p1_op;
            r_p2_index   <= r_p1_index;
            r_p2_value   <= r_p1_value;
            r_p2_u       <= n_u;
            r_p3_op      <= r_p2_op;
            r_p3_index   <= r_p2_index;
            r_p3_value   <= r_p2_value;
            r_p3_pos     <= n_pos;
            r_p3_raw_ix  <= n_raw_ix;
            r_p4_op      <= r_p3_op;
            r_p4_value   <= r_p3_value;
            r_p4_addr_a  <= n_addr_a;
            r_p4_addr_b  <= n_addr_b;
            r_p4_frac    <= n_frac;
            r_p5_frac    <= r_p4_frac;
            r_p6_frac    <= r_p5_frac;
            r_p6_base    <= $signed(n_rd_a);
            r_p6_slope   <= SLOPE_W'($signed(n_rd_b)) - SLOPE_W'($signed(n_rd_a));
            r_p7_base    <= r_p6_base;
            r_p7_prod    <= r_p6_slope * $signed({1'b0, r_p6_frac});
            r_out_sample <= n_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=>
        $stable({r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid,
                 r_p5_valid, r_p6_valid, r_p7_valid, r_p7_prod}))
        else $error("pipeline moved while result held");

endmodule

[tb/sv/itl_tb_pkg.sv]
// result tracker for the interpolated table lookup testbench: a copy of the
// registers and sample table, the lookup arithmetic and the result check
// depends on itl_pkg for widths, register indexes and opcodes
`timescale 1ns / 100ps

package itl_tb_pkg;
    import itl_pkg::*;

    class itl_lookup_scoreboard;
        logic signed [CFG_W-1:0]        bias;
        logic signed [CFG_W-1:0]        scale;
        logic                           periodic;
        logic [LEN_W-1:0]               length;
        logic signed [SAMPLE_WIDTH-1:0] samples [TABLE_DEPTH];
        logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
        int                             writes;
        int                             lookups;
        int                             raw_reads;
        int                             results;
        int                             errors;

        function new();
            bias      = '0;
            scale     = SCALE_ONE;
            periodic  = 1'b1;
            length    = LEN_RESET;
            writes    = 0;
            lookups   = 0;
            raw_reads = 0;
            results   = 0;
            errors    = 0;
            foreach (samples[k]) samples[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_NORM_BIAS:     bias     = data;
                CFG_NORM_SCALE:    scale    = data;
                CFG_PERIODIC_MODE: periodic = data[0];
                CFG_TABLE_LENGTH:  length   = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // out-of-range lengths act as the nearest legal one
        function longint used_length();
            if (length < LEN_MIN) return longint'(LEN_MIN);
            if (length > TABLE_DEPTH) return longint'(TABLE_DEPTH);
            return longint'(length);
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] interpolate(logic signed [PHASE_W-1:0] ph);
            longint one, len, prod, u, pos, idx, nxt, frac, slope, total, hi, lo;
            one  = longint'(1) << PHASE_FRAC_BITS;
            len  = used_length();
            // exact product, both operands fit well inside 64 bits
            prod = (longint'(ph) - longint'(bias)) * longint'(scale);
            if (periodic) begin
                u    = (prod >>> PHASE_FRAC_BITS) & (one - 1);
                pos  = u * len;
                idx  = pos >>> PHASE_FRAC_BITS;
                frac = pos & (one - 1);
                nxt  = (idx + 1 >= len) ? 0 : idx + 1;
            end else begin
                if (prod < 0)
                    u = 0;
                else if (prod >= (one << PHASE_FRAC_BITS))
                    u = one;
                else
                    u = prod >>> PHASE_FRAC_BITS;
                pos  = u * (len - 1);
                idx  = pos >>> PHASE_FRAC_BITS;
                frac = pos & (one - 1);
                if (idx >= len - 1) begin
                    idx  = len - 1;
                    nxt  = idx;
                    frac = 0;
                end else begin
                    nxt = idx + 1;
                end
            end
            slope = longint'(samples[nxt]) - longint'(samples[idx]);
            total = longint'(samples[idx]) + ((slope * frac) >>> PHASE_FRAC_BITS);
            hi    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
            lo    = -hi - 1;
            if (total > hi) total = hi;
            if (total < lo) total = lo;
            return SAMPLE_WIDTH'(total);
        endfunction

        function void note_item(logic [1:0] op, logic [ADDR_W-1:0] idx,
                                logic signed [SAMPLE_WIDTH-1:0] value,
                                logic signed [PHASE_W-1:0] ph);
            longint k;
            case (op)
                OP_WRITE: begin
                    samples[idx] = value;
                    writes++;
                end
                OP_LOOKUP: begin
                    expected_samples.push_back(interpolate(ph));
                    lookups++;
                end
                OP_RAW: begin
                    k = (longint'(idx) > used_length() - 1) ? used_length() - 1 : longint'(idx);
                    expected_samples.push_back(samples[k]);
                    raw_reads++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [SAMPLE_WIDTH-1:0] got);
            logic signed [SAMPLE_WIDTH-1:0] want;
            results++;
            if (expected_samples.size() == 0) begin
                errors++;
                $error("sample_out: no result expected, actual %0d", got);
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    errors++;
                    $error("sample_out: expected %0d, actual %0d", want, got);
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

endpackage

[tb/sv/tb.sv]
// top-level testbench for interpolated_table_lookup: drives items, register
// writes and output stalls, checks every result against itl_lookup_scoreboard
// depends on itl_pkg, itl_tb_pkg and the block under test
`timescale 1ns / 100ps

module tb;
    import itl_pkg::*;
    import itl_tb_pkg::*;

    // opcode 3 is unused: the block drops it without a result
    localparam logic [1:0]           OP_UNUSED     = 2'd3;
    // indexes 4 to 7 hold no register, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd4;
    // time allowed for results and table writes to work through the pipeline
    localparam int                   SETTLE_CYCLES = 12;
    // cycles with no handshake at all before the run is declared hung
    localparam int                   QUIET_LIMIT   = 5000;
    localparam int                   BLOCKS        = 8;
    localparam int                   BLOCK_ITEMS   = 52;
    // entries below this are loaded and read; the last entry is loaded too
    localparam int                   FILL_ENTRIES  = 256;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [1:0]                     i_opcode;
    logic [ADDR_W-1:0]              i_entry_index;
    logic signed [SAMPLE_WIDTH-1:0] i_entry_value;
    logic signed [PHASE_W-1:0]      i_phase;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic signed [SAMPLE_WIDTH-1:0] o_sample_out;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index;
    logic [CFG_W-1:0]               i_cfg_data;

    int                             in_idle_pct   = 0;
    int                             out_stall_pct = 0;
    int                             quiet_cycles  = 0;
    int                             settings      = 0;
    // bias as last written, so lookups can aim near the normalised range
    logic [CFG_W-1:0]               cur_bias      = '0;

    itl_lookup_scoreboard sb = new();

    interpolated_table_lookup uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_phase       (i_phase),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stalls a random share of cycles, set per phase
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // all three channels are observed here, at the edge where they complete;
    // register writes are applied before items so an item seen later uses them
    always @(posedge i_clk) begin : monitor
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_item(i_opcode, i_entry_index, i_entry_value, i_phase);
                moved = 1'b1;
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                sb.check_result(o_sample_out);
                moved = 1'b1;
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // hang detection
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $error("no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // phases: fully random, within one unit either side of the bias,
    // extremes, and whole units off the bias (hits exactly 1.0 at unit scale)
    function automatic logic [PHASE_W-1:0] pick_phase();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return cur_bias + $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
            8: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return cur_bias;
                endcase
            end
            default: return cur_bias + (PHASE_W'($urandom_range(4)) << PHASE_FRAC_BITS)
                            - 32'h0200_0000;
        endcase
    endfunction

    // one item, after a random idle gap; returns at the accepting edge
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] idx,
                             input logic [SAMPLE_WIDTH-1:0] value,
                             input logic [PHASE_W-1:0] ph);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= idx;
        i_entry_value <= value;
        i_phase       <= ph;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // register write; valid stays up so back-to-back writes need no toggle
    task automatic configure(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // sender holds off until every result is back, then lets writes that
    // carry no result work through the pipe; checked on the falling edge
    // so the monitor has already run for the edge before
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1:       begin in_idle_pct = 78; out_stall_pct = 0;  end
            2:       begin in_idle_pct = 0;  out_stall_pct = 78; end
            default: begin in_idle_pct = 29; out_stall_pct = 29; end
        endcase
    endtask

    // register setting for one random block; blocks 1 to 3 pin extremes of
    // bias and scale, blocks 4 to 7 pin lengths, the rest is random; lengths stay
    // within the loaded part of the table
    task automatic apply_setting(input int blk);
        logic [CFG_W-1:0] bias_w;
        logic [CFG_W-1:0] scale_w;
        logic [CFG_W-1:0] mag;
        logic [LEN_W-1:0] len_w;
        bias_w = ($urandom_range(3) == 0) ? '0 : 32'($signed($urandom) >>> $urandom_range(31));
        case ($urandom_range(9))
            0, 1, 2, 3: scale_w = SCALE_ONE;
            4, 5, 6: begin
                mag     = $urandom_range(32'h0400_0000);
                scale_w = $urandom_range(1) ? -mag : mag;
            end
            default: scale_w = $urandom;
        endcase
        case (blk)
            1: begin bias_w = 32'h8000_0000; scale_w = 32'h7FFF_FFFF; end
            2: begin bias_w = 32'h7FFF_FFFF; scale_w = 32'h8000_0000; end
            3: scale_w = '0;
            default: ;
        endcase
        case (blk)
            4:       len_w = LEN_MIN;
            5:       len_w = LEN_W'(FILL_ENTRIES);
            6:       len_w = '0;          // below the minimum, acts as two
            7:       len_w = LEN_W'(FILL_ENTRIES - 1);
            default: len_w = LEN_W'($urandom_range(1) ? $urandom_range(FILL_ENTRIES, 2)
                                                      : $urandom_range(40, 2));
        endcase
        configure(CFG_NORM_BIAS, bias_w);
        configure(CFG_NORM_SCALE, scale_w);
        configure(CFG_SPARE + CFG_IDX_W'($urandom_range(3)), $urandom);
        configure(CFG_PERIODIC_MODE, ($urandom & ~32'd1) | CFG_W'(blk[0]));
        configure(CFG_TABLE_LENGTH, ($urandom & ~32'h7FF) | CFG_W'(len_w));
        i_cfg_valid <= 1'b0;
        cur_bias = bias_w;
        settings++;
    endtask

    // mostly lookups and raw reads over the loaded table, some table
    // rewrites and a few unused opcodes; the unused ones are not counted
    task automatic run_block(input int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 15)
                send_item(OP_WRITE, ADDR_W'($urandom_range(FILL_ENTRIES - 1)),
                          pick_sample(), $urandom);
            else if (r < 60)
                send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom),
                          pick_phase());
            else if (r < 95)
                send_item(OP_RAW,
                          ADDR_W'($urandom_range(1) ? $urandom
                                  : $urandom_range(32'(sb.used_length() - 1))),
                          SAMPLE_WIDTH'($urandom), $urandom);
            else
                send_item(OP_UNUSED, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), $urandom);
            if (r < 95) sent++;
        end
    endtask

    initial begin : main
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_WRITE;
        i_entry_index <= '0;
        i_entry_value <= '0;
        i_phase       <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_NORM_BIAS;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the table powers up undefined: load the low entries and the last
        // one before any read, with full-scale values now and then
        for (int k = 0; k < FILL_ENTRIES; k++)
            send_item(OP_WRITE, ADDR_W'(k), pick_sample(), $urandom);
        send_item(OP_WRITE, ADDR_W'(TABLE_DEPTH - 1), pick_sample(), $urandom);

        // directed, reset registers: periodic, full length, unit scale, no bias;
        // every phase here lands on the first or the last entry, or on 5 and 6
        send_item(OP_RAW, '0, SAMPLE_WIDTH'($urandom), $urandom);
        send_item(OP_RAW, '1, SAMPLE_WIDTH'($urandom), $urandom);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h0000_0000);
        // just below one: last entry blends towards entry zero
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h00FF_FFFF);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h8000_0000);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h7FFF_FFFF);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'hFFFF_FFFF);
        send_item(OP_UNUSED, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), $urandom);
        // full-scale step between two neighbours, read back and halfway
        send_item(OP_WRITE, 10'd5, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, $urandom);
        send_item(OP_WRITE, 10'd6, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, $urandom);
        send_item(OP_RAW, 10'd5, SAMPLE_WIDTH'($urandom), $urandom);
        send_item(OP_RAW, 10'd6, SAMPLE_WIDTH'($urandom), $urandom);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h0001_6000);

        // clamp mode with a length below the minimum, so two entries in use;
        // this is also the first hold-off until all results are home
        wait_drain();
        configure(CFG_PERIODIC_MODE, '0);
        configure(CFG_TABLE_LENGTH, 32'd1);
        i_cfg_valid <= 1'b0;
        settings++;
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h0100_0000);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h0080_0000);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'hF000_0000);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h7FFF_FFFF);
        send_item(OP_RAW, 10'd700, SAMPLE_WIDTH'($urandom), $urandom);

        // length above the table acts as full depth; a write to a spare index;
        // clamped phases reach only the first and the last entry
        wait_drain();
        configure(CFG_TABLE_LENGTH, 32'h0000_07FF);
        configure(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
        settings++;
        send_item(OP_RAW, '1, SAMPLE_WIDTH'($urandom), $urandom);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'hFF00_0000);
        send_item(OP_LOOKUP, ADDR_W'($urandom), SAMPLE_WIDTH'($urandom), 32'h0100_0000);

        // random blocks, each with its own setting and idling pattern
        for (int blk = 0; blk < BLOCKS; blk++) begin
            wait_drain();
            set_idle(0);
            apply_setting(blk);
            set_idle(blk % 4);
            run_block(BLOCK_ITEMS);
        end

        wait_drain();
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("sample_out: %0d expected results never arrived", sb.pending());
        end
        $display("covered %0d table writes, %0d lookups and %0d raw reads over %0d settings",
                 sb.writes, sb.lookups, sb.raw_reads, settings);
        $display("%0d results checked, %0d failures", sb.results, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
